// ----- design/trvg_pkg.sv -----
// Shared constants, tables and types for the tube ring vertex generator.
package trvg_pkg;

  localparam int unsigned SIDES_W        = 5;
  localparam int unsigned MAX_SIDES_DEF  = 31;
  localparam logic [4:0]  SIDES_RESET    = 5'd8;
  localparam logic [4:0]  SIDES_MIN      = 5'd3;

  localparam int unsigned IN_DATA_W   = 224;
  localparam int unsigned OUT_DATA_W  = 152;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned XY_W         = 34;
  localparam int unsigned Z_W          = 33;
  localparam int unsigned TRIG_W       = 18;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef logic [31:0] atan_tab_t [CORDIC_STEPS];

  localparam atan_tab_t ATAN_TURNS = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667333,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861
  };

  typedef struct packed {
    logic                     done;
    logic signed [TRIG_W-1:0] c16;
    logic signed [TRIG_W-1:0] s16;
  } trig_res_t;

endpackage

// ----- design/tube_ring_vertex_generator.sv -----
// Tube ring vertex generator: sequencer around one shared multiplier and divider.
//
//   channel  | dir | handshake              | payload
//   s_axis   | in  | tvalid/tready          | ring (tdata), start_of_list (tuser)
//   m_axis   | out | tvalid/tready, tlast   | vertex (tdata), which_ring (tuser)
//   cfg      | in  | cfg_we_i               | sides (cfg_wdata_i)
//
// Sequence: a ring with no output is only accepted. Otherwise a phase step division
// runs, then per ring a cross product and per vertex a CORDIC, the normalizing shifts,
// a square root and three divides.
// Reset clears the state machine, the kept-ring flag and sets sides to 8.
// s_axis_tready_o is high only while idle; a stalled m_axis holds the vertex.
module tube_ring_vertex_generator #(
  parameter int unsigned MAX_SIDES = trvg_pkg::MAX_SIDES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // center_x, center_y, center_z, up_x/y/z, right_x/y/z, radius, pad
  input  logic [trvg_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // start_of_list
  input  logic                                s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, vertex_number, pad
  output logic [trvg_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  // which_ring
  output logic                                m_axis_tuser_o,
  output logic                                m_axis_tlast_o,
  input  logic                                cfg_we_i,
  input  logic [trvg_pkg::SIDES_W-1:0]        cfg_wdata_i
);
  import trvg_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_DIVN  = 12'b000000000010,
    S_CROSS = 12'b000000000100,
    S_CORD  = 12'b000000001000,
    S_DIR   = 12'b000000010000,
    S_POS   = 12'b000000100000,
    S_NORM  = 12'b000001000000,
    S_SQ    = 12'b000010000000,
    S_SQRT  = 12'b000100000000,
    S_DIVL  = 12'b001000000000,
    S_DIV   = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_e;

  localparam logic [4:0] MaxN = 5'(MAX_SIDES);

  state_e state_q;
  logic [4:0] sides_q, n_q, n_d, j_q, prem_q, incr_q;
  logic have_prev_q, which_q;
  logic [5:0] t_q;
  logic [1:0] k_q;

  logic signed [31:0] prev_cen_q [3];
  logic signed [15:0] prev_up_q  [3];
  logic signed [15:0] prev_rt_q  [3];
  logic [30:0]        prev_rad_q;
  logic signed [31:0] w_cen_q [3];
  logic signed [15:0] w_up_q  [3];
  logic signed [15:0] w_rt_q  [3];
  logic [30:0]        w_rad_q;

  logic [31:0] phase_q, inc_q;
  logic signed [32:0] cr_q [3];
  logic signed [TRIG_W-1:0] c16_q, s16_q;
  logic signed [49:0] d_q [3];
  logic [48:0] mag_q [3];
  logic [63:0] acc_q, res_q, bit_q, rb;
  logic [31:0] len_q;
  logic [47:0] dv_r_q, dv_d_q, dv_r_n;
  logic [31:0] dv_quo_q, dv_quo_n;
  logic dv_ge;
  logic signed [31:0] pos_q [3];
  logic [15:0] nrm_q [3];

  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [65:0] prod_q;

  logic [5:0] tm;
  logic [1:0] kd, kp;
  logic signed [33:0] d28;
  logic signed [65:0] pr;
  logic signed [38:0] pv;
  logic [5:0] psum;
  logic in_acc, out_acc, emit, cord_start, any_big, all_small, all_zero;
  trig_res_t trig;

  function automatic logic signed [31:0] sat32(input logic signed [38:0] v);
    if (v > 39'sh007FFFFFFF)       return 32'sh7FFFFFFF;
    else if (v < -39'sh0080000000) return 32'sh80000000;
    else                           return v[31:0];
  endfunction

  assign n_d = (sides_q < SIDES_MIN) ? SIDES_MIN : ((sides_q > MaxN) ? MaxN : sides_q);
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = (state_q == S_OUT);
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;
  assign emit = !s_axis_tuser_i && have_prev_q;
  assign cord_start = (state_q == S_CORD) && (t_q == 6'd0);

  assign m_axis_tdata_o = {3'b000, j_q, nrm_q[2], nrm_q[1], nrm_q[0],
                           pos_q[2], pos_q[1], pos_q[0]};
  assign m_axis_tuser_o = which_q;
  assign m_axis_tlast_o = which_q && (j_q == n_q);

  trvg_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .phase_i (phase_q),
    .res_o   (trig)
  );

  always_comb begin
    tm = t_q - 6'd1;
    kd = t_q[2:1];
    kp = t_q[1:0];
    d28 = '0;
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_CROSS: begin
        case (t_q)
          6'd0:    begin mul_a = 34'(w_up_q[1]); mul_b = 32'(w_rt_q[2]); end
          6'd1:    begin mul_a = 34'(w_up_q[2]); mul_b = 32'(w_rt_q[1]); end
          6'd2:    begin mul_a = 34'(w_up_q[2]); mul_b = 32'(w_rt_q[0]); end
          6'd3:    begin mul_a = 34'(w_up_q[0]); mul_b = 32'(w_rt_q[2]); end
          6'd4:    begin mul_a = 34'(w_up_q[0]); mul_b = 32'(w_rt_q[1]); end
          6'd5:    begin mul_a = 34'(w_up_q[1]); mul_b = 32'(w_rt_q[0]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      S_DIR: begin
        if (t_q < 6'd6) begin
          if (!t_q[0]) begin
            mul_a = 34'(w_rt_q[kd]);
            mul_b = 32'(c16_q);
          end else begin
            mul_a = 34'(cr_q[kd]);
            mul_b = 32'(s16_q);
          end
        end
      end
      S_POS: begin
        if (t_q < 6'd3) begin
          d28 = 34'((d_q[kp] + 50'sd32768) >>> 16);
          mul_a = d28;
          mul_b = signed'({1'b0, w_rad_q});
        end
      end
      S_SQ: begin
        if (t_q < 6'd3) begin
          mul_a = signed'({3'b000, mag_q[kp][30:0]});
          mul_b = signed'({1'b0, mag_q[kp][30:0]});
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    dv_ge    = dv_r_q >= dv_d_q;
    dv_r_n   = dv_ge ? (dv_r_q - dv_d_q) : dv_r_q;
    dv_quo_n = {dv_quo_q[30:0], dv_ge};
    rb       = res_q + bit_q;
    pr       = prod_q + 66'sd134217728;
    pv       = 39'(signed'(pr[65:28])) + 39'(w_cen_q[tm[1:0]]);
    psum     = {1'b0, prem_q} + {1'b0, incr_q};
    any_big   = (mag_q[0][48:31] != '0) || (mag_q[1][48:31] != '0) ||
                (mag_q[2][48:31] != '0);
    all_small = !mag_q[0][30] && !mag_q[1][30] && !mag_q[2][30];
    all_zero  = (mag_q[0] == '0) && (mag_q[1] == '0) && (mag_q[2] == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sides_q     <= SIDES_RESET;
      have_prev_q <= 1'b0;
      t_q         <= '0;
      k_q         <= '0;
      which_q     <= 1'b0;
      j_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        sides_q <= cfg_wdata_i;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            have_prev_q <= 1'b1;
            which_q     <= 1'b0;
            j_q         <= '0;
            t_q         <= '0;
            if (emit) begin
              state_q <= S_DIVN;
            end
          end
        end
        S_DIVN: begin
          t_q <= t_q + 6'd1;
          if (t_q == 6'd32) begin
            t_q     <= '0;
            state_q <= S_CROSS;
          end
        end
        S_CROSS, S_DIR: begin
          t_q <= t_q + 6'd1;
          if (t_q == 6'd6) begin
            t_q     <= '0;
            state_q <= (state_q == S_CROSS) ? S_CORD : S_POS;
          end
        end
        S_CORD: begin
          if (t_q == 6'd0) begin
            t_q <= 6'd1;
          end else if (trig.done) begin
            t_q     <= '0;
            state_q <= S_DIR;
          end
        end
        S_POS: begin
          t_q <= t_q + 6'd1;
          if (t_q == 6'd3) begin
            t_q     <= '0;
            state_q <= S_NORM;
          end
        end
        S_NORM: begin
          if (all_zero) begin
            state_q <= S_OUT;
          end else if (!any_big && !all_small) begin
            t_q     <= '0;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          t_q <= t_q + 6'd1;
          if (t_q == 6'd3) begin
            t_q     <= '0;
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          t_q <= t_q + 6'd1;
          if (t_q == 6'd31) begin
            k_q     <= '0;
            state_q <= S_DIVL;
          end
        end
        S_DIVL: begin
          t_q     <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          t_q <= t_q + 6'd1;
          if (t_q == 6'd14) begin
            if (k_q == 2'd2) begin
              state_q <= S_OUT;
            end else begin
              k_q     <= k_q + 2'd1;
              state_q <= S_DIVL;
            end
          end
        end
        S_OUT: begin
          if (out_acc) begin
            t_q <= '0;
            if (j_q == n_q) begin
              j_q <= '0;
              if (!which_q) begin
                which_q <= 1'b1;
                state_q <= S_CROSS;
              end else begin
                state_q <= S_IDLE;
              end
            end else begin
              j_q     <= j_q + 5'd1;
              state_q <= S_CORD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          n_q <= n_d;
          for (int i = 0; i < 3; i++) begin
            w_cen_q[i]    <= prev_cen_q[i];
            w_up_q[i]     <= prev_up_q[i];
            w_rt_q[i]     <= prev_rt_q[i];
            prev_cen_q[i] <= s_axis_tdata_i[32*i +: 32];
            prev_up_q[i]  <= s_axis_tdata_i[96 + 16*i +: 16];
            prev_rt_q[i]  <= s_axis_tdata_i[144 + 16*i +: 16];
          end
          w_rad_q    <= prev_rad_q;
          prev_rad_q <= s_axis_tdata_i[222:192];
          dv_r_q     <= 48'h0001_0000_0000;
          dv_d_q     <= {11'd0, n_d, 32'd0};
          dv_quo_q   <= '0;
          phase_q    <= '0;
          prem_q     <= '0;
        end
      end
      S_DIVN, S_DIV: begin
        dv_r_q   <= dv_r_n;
        dv_d_q   <= dv_d_q >> 1;
        dv_quo_q <= dv_quo_n;
        if (state_q == S_DIVN && t_q == 6'd32) begin
          inc_q  <= dv_quo_n;
          incr_q <= dv_r_n[4:0];
        end
        if (state_q == S_DIV && t_q == 6'd14) begin
          nrm_q[k_q] <= d_q[k_q][49] ? (16'd0 - {1'b0, dv_quo_n[14:0]})
                                     : {1'b0, dv_quo_n[14:0]};
        end
      end
      S_CROSS: begin
        if (t_q != 6'd0) begin
          if (!tm[0]) cr_q[tm[2:1]] <= prod_q[32:0];
          else        cr_q[tm[2:1]] <= cr_q[tm[2:1]] - prod_q[32:0];
        end
      end
      S_CORD: begin
        if (trig.done) begin
          c16_q <= trig.c16;
          s16_q <= trig.s16;
        end
      end
      S_DIR: begin
        if (t_q != 6'd0) begin
          if (!tm[0]) d_q[tm[2:1]] <= {prod_q[35:0], 14'd0};
          else        d_q[tm[2:1]] <= d_q[tm[2:1]] + prod_q[49:0];
        end
      end
      S_POS: begin
        if (t_q == 6'd0) begin
          for (int i = 0; i < 3; i++) begin
            mag_q[i] <= d_q[i][49] ? 49'(-d_q[i]) : 49'(d_q[i]);
          end
        end else begin
          pos_q[tm[1:0]] <= sat32(pv);
        end
      end
      S_NORM: begin
        if (all_zero) begin
          for (int i = 0; i < 3; i++) nrm_q[i] <= '0;
          for (int i = 0; i < 3; i++) pos_q[i] <= w_cen_q[i];
        end else if (any_big) begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
        end else if (all_small) begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
        end else begin
          acc_q <= '0;
        end
      end
      S_SQ: begin
        if (t_q != 6'd0) acc_q <= acc_q + prod_q[63:0];
        res_q <= '0;
        bit_q <= 64'h4000_0000_0000_0000;
      end
      S_SQRT: begin
        if (acc_q >= rb) begin
          acc_q <= acc_q - rb;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (t_q == 6'd31) begin
          len_q <= (acc_q >= rb) ? 32'((res_q >> 1) + bit_q) : 32'(res_q >> 1);
        end
      end
      S_DIVL: begin
        dv_r_q   <= {3'd0, mag_q[k_q][30:0], 14'd0} + {17'd0, len_q[31:1]};
        dv_d_q   <= {2'd0, len_q, 14'd0};
        dv_quo_q <= '0;
      end
      S_OUT: begin
        if (out_acc) begin
          if (j_q == n_q) begin
            phase_q <= '0;
            prem_q  <= '0;
            if (!which_q) begin
              for (int i = 0; i < 3; i++) begin
                w_cen_q[i] <= prev_cen_q[i];
                w_up_q[i]  <= prev_up_q[i];
                w_rt_q[i]  <= prev_rt_q[i];
              end
              w_rad_q <= prev_rad_q;
            end
          end else if (psum >= {1'b0, n_q}) begin
            phase_q <= phase_q + inc_q + 32'd1;
            prem_q  <= 5'(psum - {1'b0, n_q});
          end else begin
            phase_q <= phase_q + inc_q;
            prem_q  <= psum[4:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !m_axis_tvalid_o) else $error("input and output open together");
  a_last_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> m_axis_tuser_o)
    else $error("last vertex not on current ring");
  a_vnum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (j_q <= n_q)) else $error("vertex number beyond sides");
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && m_axis_tlast_o) |=> s_axis_tready_o) else $error("no idle after last");
`endif

endmodule

// ----- design/trvg_cordic.sv -----
// Iterative CORDIC in turns: one rotation step per cycle, cos/sin rounded to Q16.
module trvg_cordic (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [31:0]       phase_i,
  output trvg_pkg::trig_res_t res_o
);
  import trvg_pkg::*;

  logic signed [XY_W-1:0] x_q, y_q;
  logic signed [Z_W-1:0]  z_q;
  logic [1:0]             quad_q;
  logic [3:0]             i_q;
  logic                   run_q, done_q;

  logic signed [XY_W-1:0] xs, ys, c, s, cr, sr;
  logic signed [Z_W-1:0]  at;

  always_comb begin
    xs = x_q >>> i_q;
    ys = y_q >>> i_q;
    at = Z_W'(signed'({1'b0, ATAN_TURNS[i_q]}));
    case (quad_q)
      2'd0:    begin c = x_q;  s = y_q;  end
      2'd1:    begin c = -y_q; s = x_q;  end
      2'd2:    begin c = -x_q; s = -y_q; end
      default: begin c = y_q;  s = -x_q; end
    endcase
    cr = c + XY_W'(8192);
    sr = s + XY_W'(8192);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        i_q   <= '0;
      end else if (run_q) begin
        i_q <= i_q + 4'd1;
        if (i_q == 4'(CORDIC_STEPS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= CORDIC_GAIN;
      y_q    <= '0;
      z_q    <= Z_W'({3'b000, phase_i[29:0]});
      quad_q <= phase_i[31:30];
    end else if (run_q) begin
      if (!z_q[Z_W-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  assign res_o.done = done_q;
  assign res_o.c16  = cr[31:14];
  assign res_o.s16  = sr[31:14];

`ifndef SYNTHESIS
  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(run_q)) else $error("done without run");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !run_q) else $error("start while running");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held");
`endif

endmodule
